### rtl/gfp_pkg.sv
// Shared constants, types and the read plan for the GNSS frame parser.
package gfp_pkg;

   localparam int MAX_PAYLOAD  = 512;
   localparam int MAX_CHANNELS = 64;
   localparam int RES_LIMIT    = 42;
   localparam int CHAN_CAP     = (MAX_CHANNELS < RES_LIMIT) ? MAX_CHANNELS : RES_LIMIT;
   localparam int ADDR_W       = $clog2(MAX_PAYLOAD);
   localparam int LEN_W        = $clog2(MAX_PAYLOAD + 1);
   localparam int NUM_W        = $clog2(CHAN_CAP + 1);
   localparam int NUM_SLOTS    = 23;
   localparam int SLOT_W       = 5;
   localparam int OFF_W        = 6;
   localparam int SAT_HDR      = 8;
   localparam int SAT_STRIDE   = 12;
   // x/12 == (x*683)>>13 for every x below 2048
   localparam int RECIP_12     = 683;
   localparam int RECIP_SH     = 13;

   localparam logic [7:0] SYNC_1    = 8'hB5;
   localparam logic [7:0] SYNC_2    = 8'h62;
   localparam logic [7:0] CLASS_NAV = 8'h01;
   localparam logic [7:0] ID_PVT    = 8'h07;
   localparam logic [7:0] ID_SAT    = 8'h35;
   localparam logic [7:0] ID_CLOCK  = 8'h22;
   localparam int PVT_MIN   = 92;
   localparam int CLOCK_MIN = 20;
   localparam int SAT_MIN   = 8;

   localparam logic [1:0] KIND_PVT      = 2'd0;
   localparam logic [1:0] KIND_SAT      = 2'd1;
   localparam logic [1:0] KIND_SAT_LAST = 2'd2;
   localparam logic [1:0] KIND_CLOCK    = 2'd3;

   localparam int EN_PVT   = 0;
   localparam int EN_SAT   = 1;
   localparam int EN_CLOCK = 2;

   typedef enum logic [1:0] {MODE_PVT, MODE_CLOCK, MODE_SAT} mode_type;

   typedef struct packed {
      logic             valid;
      mode_type         mode;
      logic [LEN_W-1:0] len;
   } start_type;

   typedef struct packed {
      logic [OFF_W-1:0]  off;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } plan_type;

   // Slots 0..6 are byte_a..byte_g, slots 7..22 the four words, low byte first.
   function automatic plan_type plan_fn(mode_type mode, logic [SLOT_W-1:0] step);
      plan_type p;
      p = '{off: '0, slot: '0, last: 1'b1};
      case (mode)
         MODE_PVT: begin
            p.last = (step == SLOT_W'(20));
            case (step)
               5'd0:  p = '{off: 6'd6,  slot: 5'd0,  last: 1'b0};
               5'd1:  p = '{off: 6'd7,  slot: 5'd1,  last: 1'b0};
               5'd2:  p = '{off: 6'd8,  slot: 5'd2,  last: 1'b0};
               5'd3:  p = '{off: 6'd9,  slot: 5'd3,  last: 1'b0};
               5'd4:  p = '{off: 6'd10, slot: 5'd4,  last: 1'b0};
               5'd5:  p = '{off: 6'd20, slot: 5'd5,  last: 1'b0};
               5'd6:  p = '{off: 6'd23, slot: 5'd6,  last: 1'b0};
               5'd19: p = '{off: 6'd4,  slot: 5'd19, last: 1'b0};
               5'd20: p = '{off: 6'd5,  slot: 5'd20, last: 1'b1};
               default: begin
                  // longitude, latitude, then height at 36
                  p.slot = step;
                  p.off  = (step < 5'd15) ? OFF_W'(step + 5'd17) : OFF_W'(step + 5'd21);
                  p.last = 1'b0;
               end
            endcase
         end
         MODE_CLOCK: begin
            p.off  = OFF_W'(step) + OFF_W'(4);
            p.slot = step + SLOT_W'(7);
            p.last = (step == SLOT_W'(15));
         end
         MODE_SAT: begin
            case (step)
               5'd0:    p = '{off: 6'd0, slot: 5'd0, last: 1'b0};
               5'd1:    p = '{off: 6'd1, slot: 5'd1, last: 1'b0};
               5'd2:    p = '{off: 6'd2, slot: 5'd2, last: 1'b0};
               5'd3:    p = '{off: 6'd3, slot: 5'd3, last: 1'b0};
               5'd4:    p = '{off: 6'd8, slot: 5'd4, last: 1'b0};
               5'd5:    p = '{off: 6'd4, slot: 5'd7, last: 1'b0};
               default: p = '{off: 6'd5, slot: 5'd8, last: 1'b1};
            endcase
         end
         default: p = '{off: '0, slot: '0, last: 1'b1};
      endcase
      return p;
   endfunction

endpackage

### rtl/gfp_ram.sv
// Generic simple dual-port RAM with registered read.
module gfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/gfp_decode.sv
// Decode sequencer: reads the payload store and emits result transactions.
module gfp_decode
   import gfp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  start_type           start,
   output logic                busy,
   output logic [ADDR_W-1:0]   rd_addr,
   input  logic [7:0]          rd_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [183:0]        rsp_tdata,
   output logic [1:0]          rsp_tuser
);
   typedef enum logic [2:0] {S_IDLE, S_CNT_RD, S_CNT_WAIT, S_ADDR, S_DATA, S_EMIT} state_type;

   state_type         state_ff;
   mode_type          mode_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  base_ff;
   logic [SLOT_W-1:0] step_ff;
   logic [NUM_W-1:0]  num_ff, chan_ff;
   logic [1:0]        kind_ff;
   logic [7:0]        slot_ff [NUM_SLOTS];

   plan_type               plan;
   logic [LEN_W-1:0]       avail;
   logic [LEN_W+9:0]       quot_prod;
   logic [LEN_W-1:0]       quot;
   logic [11:0]            need;
   logic [LEN_W-1:0]       cnt_a;
   logic [NUM_W-1:0]       num_in;
   logic [LEN_W-1:0]       sum_addr;

   assign plan      = plan_fn(mode_ff, step_ff);
   assign avail     = len_ff - LEN_W'(SAT_HDR);
   assign quot_prod = (LEN_W+10)'(avail) * (LEN_W+10)'(RECIP_12);
   assign quot      = LEN_W'(quot_prod >> RECIP_SH);
   assign need      = 12'(rd_data) * 12'(SAT_STRIDE) + 12'(SAT_HDR);

   always_comb begin
      if (32'(need) > 32'(len_ff)) begin
         cnt_a = quot;
      end else begin
         cnt_a = LEN_W'(rd_data);
      end
      if (32'(cnt_a) > 32'(CHAN_CAP)) begin
         num_in = NUM_W'(CHAN_CAP);
      end else begin
         num_in = NUM_W'(cnt_a);
      end
   end

   assign sum_addr = base_ff + LEN_W'(plan.off);

   always_comb begin
      rd_addr = sum_addr[ADDR_W-1:0];
      if (state_ff == S_CNT_RD) begin
         rd_addr = ADDR_W'(5);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start.valid) begin
                  mode_ff <= start.mode;
                  len_ff  <= start.len;
                  base_ff <= '0;
                  step_ff <= '0;
                  chan_ff <= '0;
                  for (int i = 0; i < NUM_SLOTS; i++) slot_ff[i] <= '0;
                  case (start.mode)
                     MODE_PVT:   kind_ff <= KIND_PVT;
                     MODE_CLOCK: kind_ff <= KIND_CLOCK;
                     default:    kind_ff <= KIND_SAT;
                  endcase
                  if (start.mode == MODE_SAT) begin
                     base_ff  <= LEN_W'(SAT_HDR);
                     state_ff <= S_CNT_RD;
                  end else begin
                     state_ff <= S_ADDR;
                  end
               end
            end
            S_CNT_RD: state_ff <= S_CNT_WAIT;
            S_CNT_WAIT: begin
               num_ff <= num_in;
               if (num_in == '0) begin
                  kind_ff  <= KIND_SAT_LAST;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_ADDR;
               end
            end
            S_ADDR: state_ff <= S_DATA;
            S_DATA: begin
               if (mode_ff == MODE_SAT && plan.slot == SLOT_W'(4)) begin
                  slot_ff[plan.slot] <= {7'd0, rd_data[3]};
               end else begin
                  slot_ff[plan.slot] <= rd_data;
               end
               if (plan.last) begin
                  if (mode_ff == MODE_SAT) begin
                     // azimuth sign extension, channel index and count
                     slot_ff[9]  <= {8{rd_data[7]}};
                     slot_ff[10] <= {8{rd_data[7]}};
                     slot_ff[5]  <= 8'(chan_ff);
                     slot_ff[6]  <= 8'(num_ff);
                     kind_ff     <= (chan_ff + NUM_W'(1) == num_ff) ? KIND_SAT_LAST : KIND_SAT;
                  end
                  state_ff <= S_EMIT;
               end else begin
                  step_ff  <= step_ff + SLOT_W'(1);
                  state_ff <= S_ADDR;
               end
            end
            S_EMIT: begin
               if (rsp_tready) begin
                  if (mode_ff == MODE_SAT && chan_ff + NUM_W'(1) < num_ff) begin
                     chan_ff  <= chan_ff + NUM_W'(1);
                     base_ff  <= base_ff + LEN_W'(SAT_STRIDE);
                     step_ff  <= '0;
                     state_ff <= S_ADDR;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tuser  = kind_ff;

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) rsp_tdata[i*8 +: 8] = slot_ff[i];
   end
endmodule

### rtl/gnss_binary_frame_parser.sv
// Top level: byte-stream frame parser, payload store and decode sequencer.
// Throughput: one byte per cycle while framing; intake stops while a frame is decoded
// (the sequencer reads its payload bytes from the dual-port store) and while results stall.
// Reset (synchronous) returns to the sync hunt with enable_mask 7; no memory clear.
module gnss_binary_frame_parser
   import gfp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] kind
   output logic [1:0]   rsp_tuser,
   // byte_a..byte_g [55:0], word_a [87:56], word_b [119:88],
   // word_c [151:120], word_d [183:152]
   output logic [183:0] rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_wr_data
);
   typedef enum logic [3:0] {
      PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LENLO, PH_LENHI, PH_PAYLOAD, PH_CKA, PH_CKB
   } phase_type;

   phase_type        phase_ff;
   logic [2:0]       enable_ff;
   logic [LEN_W-1:0] pos_ff, len_ff;
   logic [7:0]       len_lo_ff, class_ff, id_ff, sum_a_ff, sum_b_ff, ck_a_ff;

   logic              accept, busy, wr_en;
   logic [7:0]        v, sum_a_in, rd_data;
   logic [15:0]       full_len;
   logic [ADDR_W-1:0] rd_addr;
   start_type         start;

   assign v          = req_tdata;
   assign req_tready = !busy && !start.valid;
   assign accept     = req_tvalid && req_tready;
   assign sum_a_in   = sum_a_ff + v;
   assign full_len   = {v, len_lo_ff};
   assign wr_en      = accept && phase_ff == PH_PAYLOAD;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 3'd7;
      end else if (csr_wr_en) begin
         enable_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC1;
         start.valid <= 1'b0;
         pos_ff      <= '0;
         len_ff      <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
      end else begin
         start.valid <= 1'b0;
         if (accept) begin
            if (phase_ff inside {PH_CLASS, PH_ID, PH_LENLO, PH_LENHI, PH_PAYLOAD}) begin
               sum_a_ff <= sum_a_in;
               sum_b_ff <= sum_b_ff + sum_a_in;
            end
            case (phase_ff)
               PH_SYNC1: if (v == SYNC_1) phase_ff <= PH_SYNC2;
               PH_SYNC2: begin
                  if (v == SYNC_2) begin
                     phase_ff <= PH_CLASS;
                     sum_a_ff <= '0;
                     sum_b_ff <= '0;
                  end else if (v != SYNC_1) begin
                     phase_ff <= PH_SYNC1;
                  end
               end
               PH_CLASS: begin
                  class_ff <= v;
                  phase_ff <= PH_ID;
               end
               PH_ID: begin
                  id_ff    <= v;
                  phase_ff <= PH_LENLO;
               end
               PH_LENLO: begin
                  len_lo_ff <= v;
                  phase_ff  <= PH_LENHI;
               end
               PH_LENHI: begin
                  pos_ff <= '0;
                  if (32'(full_len) > 32'(MAX_PAYLOAD)) begin
                     len_ff   <= '0;
                     phase_ff <= PH_SYNC1;
                  end else begin
                     len_ff   <= LEN_W'(full_len);
                     phase_ff <= (full_len == 16'd0) ? PH_CKA : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  pos_ff <= pos_ff + LEN_W'(1);
                  if (pos_ff + LEN_W'(1) >= len_ff) phase_ff <= PH_CKA;
               end
               PH_CKA: begin
                  ck_a_ff  <= v;
                  phase_ff <= PH_CKB;
               end
               PH_CKB: begin
                  phase_ff   <= PH_SYNC1;
                  start.len  <= len_ff;
                  if (ck_a_ff == sum_a_ff && v == sum_b_ff && class_ff == CLASS_NAV) begin
                     if (id_ff == ID_PVT && enable_ff[EN_PVT]
                         && 32'(len_ff) >= 32'(PVT_MIN)) begin
                        start.valid <= 1'b1;
                        start.mode  <= MODE_PVT;
                     end else if (id_ff == ID_CLOCK && enable_ff[EN_CLOCK]
                                  && 32'(len_ff) >= 32'(CLOCK_MIN)) begin
                        start.valid <= 1'b1;
                        start.mode  <= MODE_CLOCK;
                     end else if (id_ff == ID_SAT && enable_ff[EN_SAT]
                                  && 32'(len_ff) >= 32'(SAT_MIN)) begin
                        start.valid <= 1'b1;
                        start.mode  <= MODE_SAT;
                     end
                  end
               end
               default: phase_ff <= PH_SYNC1;
            endcase
         end
      end
   end

   gfp_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[ADDR_W-1:0]),
      .wr_data (v),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gfp_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule

### rtl/gfp_checker.sv
// Port-level assertions for the frame parser, bound to the top level.
module gfp_checker
   import gfp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [1:0]   rsp_tuser,
   input logic [183:0] rsp_tdata
);
   // a stalled result transaction holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // intake is closed while results are pending
   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken during emission");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");

   a_clock_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_CLOCK |-> rsp_tdata[55:0] == '0)
      else $error("clock result has nonzero bytes");

   a_sat_words: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SAT || rsp_tuser == KIND_SAT_LAST)
      |-> rsp_tdata[183:88] == '0)
      else $error("satellite result has nonzero words");
endmodule

bind gnss_binary_frame_parser gfp_checker u_gfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

### test/tb_gnss_binary_frame_parser.sv
// Testbench for the GNSS binary frame parser: framed byte stream in, decoded records checked.
module tb_gnss_binary_frame_parser;
   import gfp_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 120;

   typedef enum logic [3:0] {
      HUNT_SYNC1, HUNT_SYNC2, GET_CLASS, GET_ID, GET_LENLO, GET_LENHI,
      GET_PAYLOAD, GET_CKA, GET_CKB
   } parse_phase_t;

   typedef struct packed {
      logic [1:0]   kind;
      logic [183:0] data;
   } nav_record_t;

   typedef struct {
      logic [7:0] cls;
      logic [7:0] id;
      int         len;
      logic [7:0] chan;
      int         bad_ck;   // 0 good, 1 corrupt first byte, 2 corrupt second byte
      logic [2:0] mask;
      int         want;     // typed-in record count, -1 when left to the decoder model
   } frame_row_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [1:0]   rsp_tuser;
   logic [183:0] rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic [2:0]   csr_wr_data = 3'd0;

   gnss_binary_frame_parser u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder model state
   parse_phase_t phase = HUNT_SYNC1;
   logic [2:0]   mask_model = 3'd7;
   int           pos_model, len_model;
   logic [7:0]   cls_model, id_model, sum_a, sum_b, ck_a_seen;
   logic [7:0]   pl_store [MAX_PAYLOAD];

   nav_record_t  pending_records [$];
   int           send_idle = 0, recv_idle = 0;
   int           errors = 0, cycles = 0, records_seen = 0, bytes_sent = 0, frames_sent = 0;
   int           records_predicted = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      nav_record_t exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         records_seen++;
         if (pending_records.size() == 0) begin
            errors++;
            $display("%0t: record with none pending: kind %0d data %h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            exp_r = pending_records.pop_front();
            if (exp_r.kind !== rsp_tuser) begin
               errors++;
               $display("%0t: kind expected %0d got %0d", $time, exp_r.kind, rsp_tuser);
            end
            for (int k = 0; k < 7; k++)
               if (exp_r.data[8*k +: 8] !== rsp_tdata[8*k +: 8]) begin
                  errors++;
                  $display("%0t: byte %0d expected %h got %h", $time, k,
                           exp_r.data[8*k +: 8], rsp_tdata[8*k +: 8]);
               end
            for (int k = 0; k < 4; k++)
               if (exp_r.data[56+32*k +: 32] !== rsp_tdata[56+32*k +: 32]) begin
                  errors++;
                  $display("%0t: word %0d expected %h got %h", $time, k,
                           exp_r.data[56+32*k +: 32], rsp_tdata[56+32*k +: 32]);
               end
         end
      end
   end

   function automatic logic [31:0] pl_word(int i);
      return {pl_store[i+3], pl_store[i+2], pl_store[i+1], pl_store[i]};
   endfunction

   function automatic int decode_frame();
      nav_record_t r;
      int          num, s;
      logic [31:0] az;
      r = '0;
      if (cls_model != CLASS_NAV) return 0;
      if (id_model == ID_PVT) begin
         if (!mask_model[EN_PVT] || len_model < PVT_MIN) return 0;
         r.kind = KIND_PVT;
         r.data[55:0] = {pl_store[23], pl_store[20], pl_store[10], pl_store[9],
                         pl_store[8], pl_store[7], pl_store[6]};
         r.data[87:56]   = pl_word(24);
         r.data[119:88]  = pl_word(28);
         r.data[151:120] = pl_word(36);
         r.data[183:152] = {16'd0, pl_store[5], pl_store[4]};
         pending_records.push_back(r);
         return 1;
      end
      if (id_model == ID_CLOCK) begin
         if (!mask_model[EN_CLOCK] || len_model < CLOCK_MIN) return 0;
         r.kind = KIND_CLOCK;
         r.data[87:56]   = pl_word(4);
         r.data[119:88]  = pl_word(8);
         r.data[151:120] = pl_word(12);
         r.data[183:152] = pl_word(16);
         pending_records.push_back(r);
         return 1;
      end
      if (id_model == ID_SAT) begin
         if (!mask_model[EN_SAT] || len_model < SAT_MIN) return 0;
         num = pl_store[5];
         if (SAT_HDR + num * SAT_STRIDE > len_model) num = (len_model - SAT_HDR) / SAT_STRIDE;
         if (num > MAX_CHANNELS) num = MAX_CHANNELS;
         if (num > RES_LIMIT) num = RES_LIMIT;
         if (num == 0) begin
            r.kind = KIND_SAT_LAST;
            pending_records.push_back(r);
            return 1;
         end
         for (int i = 0; i < num; i++) begin
            s  = SAT_HDR + i * SAT_STRIDE;
            az = {{16{pl_store[s+5][7]}}, pl_store[s+5], pl_store[s+4]};
            r = '0;
            r.kind = (i + 1 == num) ? KIND_SAT_LAST : KIND_SAT;
            r.data[55:0] = {8'(num), 8'(i), 7'd0, pl_store[s+8][3], pl_store[s+3],
                            pl_store[s+2], pl_store[s+1], pl_store[s]};
            r.data[87:56] = az;
            pending_records.push_back(r);
         end
         return num;
      end
      return 0;
   endfunction

   function automatic void add_sum(logic [7:0] v);
      sum_a = sum_a + v;
      sum_b = sum_b + sum_a;
   endfunction

   // advances the decoder model by one accepted byte, returns records produced
   function automatic int parse_byte(logic [7:0] v);
      int n, nres;
      nres = 0;
      case (phase)
         HUNT_SYNC1: if (v == SYNC_1) phase = HUNT_SYNC2;
         HUNT_SYNC2: begin
            if (v == SYNC_2) begin
               phase = GET_CLASS; sum_a = 0; sum_b = 0;
            end else if (v != SYNC_1) phase = HUNT_SYNC1;
         end
         GET_CLASS: begin cls_model = v; add_sum(v); phase = GET_ID; end
         GET_ID:    begin id_model = v; add_sum(v); phase = GET_LENLO; end
         GET_LENLO: begin len_model = v; add_sum(v); phase = GET_LENHI; end
         GET_LENHI: begin
            n = len_model + (int'(v) << 8);
            add_sum(v);
            pos_model = 0;
            if (n > MAX_PAYLOAD) begin
               len_model = 0; phase = HUNT_SYNC1;
            end else begin
               len_model = n;
               phase = (n == 0) ? GET_CKA : GET_PAYLOAD;
            end
         end
         GET_PAYLOAD: begin
            pl_store[pos_model] = v;
            add_sum(v);
            pos_model++;
            if (pos_model >= len_model) phase = GET_CKA;
         end
         GET_CKA: begin ck_a_seen = v; phase = GET_CKB; end
         GET_CKB: begin
            if (ck_a_seen == sum_a && v == sum_b) nres = decode_frame();
            phase = HUNT_SYNC1;
         end
         default: phase = HUNT_SYNC1;
      endcase
      return nres;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b, inout int nres);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      nres += parse_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // builds and sends one frame; cut > 0 stops after that many bytes
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
                             input logic [7:0] chan, input int bad_ck, input int extra_sync,
                             input int cut, output int nres);
      logic [7:0] fb [$];
      logic [7:0] ca, cb, v;
      ca = 0; cb = 0; nres = 0;
      repeat (extra_sync) fb.push_back(SYNC_1);
      fb.push_back(SYNC_1); fb.push_back(SYNC_2);
      fb.push_back(cls); fb.push_back(id);
      fb.push_back(len[7:0]); fb.push_back(len[15:8]);
      for (int i = 2; i < fb.size(); i++)
         if (i >= extra_sync + 2) begin ca += fb[i]; cb += ca; end
      if (len <= MAX_PAYLOAD) begin
         for (int i = 0; i < len; i++) begin
            v = (i == 5 && id == ID_SAT) ? chan : 8'($urandom);
            fb.push_back(v); ca += v; cb += ca;
         end
         fb.push_back(bad_ck == 1 ? ca ^ 8'(1 << $urandom_range(7)) : ca);
         fb.push_back(bad_ck == 2 ? cb ^ 8'(1 << $urandom_range(7)) : cb);
      end
      if (cut > 0 && cut < fb.size()) fb = fb[0:cut-1];
      foreach (fb[i]) send_byte(fb[i], nres);
      frames_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_records.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_mask(input logic [2:0] m);
      int dummy;
      dummy = 0;
      while (phase != HUNT_SYNC1) send_byte(8'h00, dummy);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      mask_model = m;
      @(negedge clock);
   endtask

   task automatic random_frame(output int nres);
      int pick, n, ch;
      pick = $urandom_range(99);
      if (pick < 28)
         send_frame(CLASS_NAV, ID_PVT, $urandom_range(PVT_MIN, PVT_MIN + 8), 0, 0,
                    $urandom_range(1) ? 0 : $urandom_range(1, 2), 0, nres);
      else if (pick < 50)
         send_frame(CLASS_NAV, ID_CLOCK, $urandom_range(CLOCK_MIN, CLOCK_MIN + 8), 0, 0,
                    0, 0, nres);
      else if (pick < 78) begin
         ch = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(6);
         n  = ($urandom_range(3) == 0) ? $urandom_range(SAT_MIN, 60)
                                       : SAT_HDR + SAT_STRIDE * (ch % 8) + $urandom_range(3);
         send_frame(CLASS_NAV, ID_SAT, n, 8'(ch), 0, 0, 0, nres);
      end else if (pick < 84)
         send_frame(CLASS_NAV, ($urandom_range(2) == 0) ? ID_PVT : ID_SAT,
                    $urandom_range(PVT_MIN, PVT_MIN + 4), 8'($urandom_range(4)),
                    $urandom_range(1, 2), 0, 0, nres);
      else if (pick < 88)
         send_frame(8'($urandom), 8'($urandom), $urandom_range(0, 24), 8'($urandom),
                    0, 0, 0, nres);
      else if (pick < 92)
         send_frame(CLASS_NAV, ID_CLOCK, $urandom_range(MAX_PAYLOAD + 1, 16'hFFFF), 0, 0,
                    0, 0, nres);
      else if (pick < 96)
         send_frame(CLASS_NAV, ID_CLOCK, $urandom_range(0, CLOCK_MIN - 1), 0, 0, 0, 0, nres);
      else
         send_frame(CLASS_NAV, ID_PVT, PVT_MIN, 0, 0, 0, $urandom_range(3, 40), nres);
      // a little line noise between frames, biased toward sync bytes
      repeat ($urandom_range(0, 3))
         send_byte($urandom_range(2) == 0 ? SYNC_1 : 8'($urandom), nres);
   endtask

   frame_row_t rows [] = '{
      '{CLASS_NAV, ID_PVT,   PVT_MIN,     8'd0,   0, 3'd7, -1},
      '{CLASS_NAV, ID_PVT,   PVT_MIN - 1, 8'd0,   0, 3'd7,  0},
      '{CLASS_NAV, ID_CLOCK, CLOCK_MIN,   8'd0,   0, 3'd7, -1},
      '{CLASS_NAV, ID_CLOCK, CLOCK_MIN-1, 8'd0,   0, 3'd7,  0},
      '{CLASS_NAV, ID_SAT,   SAT_MIN,     8'd0,   0, 3'd7,  1},
      '{CLASS_NAV, ID_SAT,   SAT_MIN - 1, 8'd0,   0, 3'd7,  0},
      '{CLASS_NAV, ID_SAT,   MAX_PAYLOAD, 8'd255, 0, 3'd7, 42},
      '{CLASS_NAV, ID_SAT,   44,          8'd3,   0, 3'd7,  3},
      '{CLASS_NAV, ID_SAT,   50,          8'd9,   0, 3'd7,  3},
      '{CLASS_NAV, ID_PVT,   PVT_MIN,     8'd0,   1, 3'd7,  0},
      '{CLASS_NAV, ID_CLOCK, CLOCK_MIN,   8'd0,   2, 3'd7,  0},
      '{8'h02,     ID_PVT,   PVT_MIN,     8'd0,   0, 3'd7,  0},
      '{CLASS_NAV, 8'h99,    CLOCK_MIN,   8'd0,   0, 3'd7,  0},
      '{CLASS_NAV, ID_CLOCK, MAX_PAYLOAD+1, 8'd0, 0, 3'd7,  0},
      '{CLASS_NAV, ID_PVT,   0,           8'd0,   0, 3'd7,  0},
      '{CLASS_NAV, ID_PVT,   PVT_MIN,     8'd0,   0, 3'd6,  0},
      '{CLASS_NAV, ID_CLOCK, CLOCK_MIN,   8'd0,   0, 3'd0,  0},
      '{CLASS_NAV, ID_SAT,   32,          8'd2,   0, 3'd2,  2},
      '{CLASS_NAV, ID_PVT,   PVT_MIN,     8'd0,   0, 3'd1,  1}
   };

   initial begin
      int nres, phase_bytes, phase_recs, dummy;
      logic [2:0] phase_mask [3];
      repeat (4) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed frames, one extra sync byte in front of each
      send_idle = 10; recv_idle = 30;
      dummy = 0;
      send_byte(SYNC_1, dummy); send_byte(8'h00, dummy); // broken sync pair
      foreach (rows[i]) begin
         if (rows[i].mask != mask_model) write_mask(rows[i].mask);
         send_frame(rows[i].cls, rows[i].id, rows[i].len, rows[i].chan, rows[i].bad_ck,
                    1, 0, nres);
         records_predicted += nres;
         if (rows[i].want >= 0 && nres != rows[i].want) begin
            errors++;
            $display("%0t: row %0d record count expected %0d got %0d",
                     $time, i, rows[i].want, nres);
         end
      end

      phase_mask[0] = 3'd7;
      phase_mask[1] = 3'($urandom_range(1, 6));
      phase_mask[2] = 3'($urandom_range(0, 7));
      for (int p = 0; p < 3; p++) begin
         send_idle = (p == 0) ? 18 : (p == 1) ? 56 : 0;
         recv_idle = (p == 0) ? 56 : (p == 1) ? 18 : 0;
         write_mask(phase_mask[p]);
         phase_bytes = bytes_sent;
         phase_recs  = 0;
         while (bytes_sent - phase_bytes < 90 || phase_recs < 20) begin
            random_frame(nres);
            phase_recs += nres;
            records_predicted += nres;
            if (p == 0 && frames_sent % 7 == 0) begin
               // hold the stream until everything pending has drained
               req_tvalid <= 1'b0;
               @(negedge clock);
               while (pending_records.size() != 0) @(negedge clock);
            end
         end
      end
      write_mask(3'd0);
      write_mask(3'd7);

      wait_idle();
      $display("sent %0d bytes in %0d frames; %0d records checked over masks and idle mixes",
               bytes_sent, frames_sent, records_seen);
      if (errors == 0 && pending_records.size() == 0 && records_seen == records_predicted)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
rtl/gfp_pkg.sv
rtl/gfp_ram.sv
rtl/gfp_decode.sv
rtl/gnss_binary_frame_parser.sv
rtl/gfp_checker.sv
test/tb_gnss_binary_frame_parser.sv
